@@ rtl/ttc_pkg.sv @@
package ttc_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ALPHA_W    = 9;
  localparam int unsigned DEG_W      = 8;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned TILT_W     = 17;
  localparam int unsigned AVG_W      = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // serial multiplier: signed multiplicand, unsigned multiplier, one bit a cycle
  localparam int unsigned MCAND_W    = 19;
  localparam int unsigned MPL_W      = 9;
  localparam int unsigned PROD_W     = 28;
  localparam int unsigned MUL_CNT_W  = 4;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MPL_W - 1);

  // serial restoring divider
  localparam int unsigned DVD_W      = 20;
  localparam int unsigned DVS_W      = 8;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

  // tilt scaling: sample * 45 / 32 gives Q.8 degrees
  localparam logic [MPL_W-1:0] RAW_SCALE = MPL_W'(45);
  localparam int unsigned RAW_SHIFT  = 5;
  localparam int unsigned AVG_SHIFT  = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(38);
  localparam logic [DEG_W-1:0]   DZ_RST    = DEG_W'(6);
  localparam logic [DEG_W-1:0]   MAX_RST   = DEG_W'(20);
  localparam logic [CODE_W-1:0]  IDLE_RST  = CODE_W'(750);
  localparam logic [CODE_W-1:0]  HI_RST    = CODE_W'(1150);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA    = 3'd0,
    CFG_DEADZONE = 3'd1,
    CFG_MAX_TILT = 3'd2,
    CFG_IDLE     = 3'd3,
    CFG_DAC_MAX  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic               start;
    logic [MCAND_W-1:0] mcand;
    logic [MPL_W-1:0]   mplier;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

@@ rtl/ttc_mul.sv @@
module ttc_mul import ttc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mul_req_t                 req_i,
  output logic                     done_o,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] mc_q, mc_d;
  logic [MPL_W-1:0]         mp_q, mp_d;
  logic [MUL_CNT_W-1:0]     cnt_q;
  logic                     busy_q, done_q;

  always_comb begin
    acc_d = acc_q;
    mc_d  = mc_q;
    mp_d  = mp_q;
    if (req_i.start) begin
      acc_d = '0;
      mc_d  = {{(PROD_W-MCAND_W){req_i.mcand[MCAND_W-1]}}, req_i.mcand};
      mp_d  = req_i.mplier;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d = mc_q <<< 1;
      mp_d = mp_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + MUL_CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ rtl/ttc_div.sv @@
module ttc_div import ttc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o
);

  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [DVS_W-1:0]     rem_q, rem_d;
  logic [DVS_W-1:0]     dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DVS_W:0]       shifted;
  logic [DVS_W+1:0]     trial;

  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (busy_q) begin
      if (trial[DVS_W+1]) begin
        rem_d = shifted[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end else begin
        rem_d = trial[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

@@ rtl/tilt_to_throttle_conditioner_unit.sv @@
// Channel   | Handshake              | Payload
// ----------+------------------------+----------------------------------------
// input     | in_valid_i/in_ready_o  | accel_sample_i (16b signed)
// output    | out_valid_o/out_ready_i| throttle_code_o (12b), filtered_tilt_o
// config    | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// From input transfer to result: three bit-serial multiplies (scale, filter,
// map) of one load and 9 steps each, a 20-step restoring divide with its load,
// and the average, select and output states. The map multiply and the divide
// are skipped when the tilt is in the deadzone or the span is zero.
// Input is taken again the cycle after the result is registered, so one item
// is worked on at a time; a waiting result holds the next item in its last step.
// Reset restores register defaults and clears the average.
module tilt_to_throttle_conditioner_unit import ttc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [SAMPLE_W-1:0]  accel_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [CODE_W-1:0]           throttle_code_o,
  output logic signed [TILT_W-1:0]    filtered_tilt_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_RAW, S_AVG, S_SEL, S_MAP, S_DIV, S_LAST
  } state_e;

  state_e                   state_q;
  logic [ALPHA_W-1:0]       alpha_q;
  logic [DEG_W-1:0]         dz_q, mx_q;
  logic [CODE_W-1:0]        lo_q, hi_q;
  logic signed [AVG_W-1:0]  avg_q;
  logic                     idle_q, dneg_q, neg_q;
  logic                     out_valid_q;
  logic [CODE_W-1:0]        code_q;
  logic signed [TILT_W-1:0] tilt_q;

  mul_req_t                 mul_req;
  div_req_t                 div_req;
  logic                     mul_done, div_done;
  logic signed [PROD_W-1:0] mul_prod;
  logic [DVD_W-1:0]         div_quo;

  logic signed [TILT_W-1:0]  raw;
  logic signed [MCAND_W-1:0] diff;
  logic [ALPHA_W-1:0]        alpha_eff;
  logic signed [AVG_W-1:0]   avg_new;
  logic signed [AVG_W-1:0]   dz_t, mx_t, t_pre, t_cl;
  logic                      t_zero, span_zero, span_neg;
  logic [DEG_W:0]            ddz, ddz_neg, span, span_negv;
  logic [MPL_W-1:0]          dmag;
  logic [DVS_W-1:0]          smag;
  logic [CODE_W:0]           hl;
  logic [PROD_W-1:0]         num_neg;
  logic [DVD_W-1:0]          nmag;
  logic [DVD_W:0]            sum;
  logic [CODE_W-1:0]         code_next;

  ttc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  ttc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign raw       = mul_prod[RAW_SHIFT+TILT_W-1:RAW_SHIFT];
  assign diff      = {{(MCAND_W-TILT_W){raw[TILT_W-1]}}, raw}
                   - {{(MCAND_W-AVG_W){avg_q[AVG_W-1]}}, avg_q};
  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign avg_new   = avg_q + mul_prod[AVG_SHIFT+AVG_W-1:AVG_SHIFT];

  assign dz_t  = {{(AVG_W-DEG_W-AVG_SHIFT){1'b0}}, dz_q, {AVG_SHIFT{1'b0}}};
  assign mx_t  = {{(AVG_W-DEG_W-AVG_SHIFT){1'b0}}, mx_q, {AVG_SHIFT{1'b0}}};
  assign t_pre = (avg_q < dz_t) ? '0 : avg_q;
  assign t_cl  = (t_pre > mx_t) ? mx_t : t_pre;
  assign t_zero    = (t_cl == '0);
  assign span_zero = (mx_q == dz_q);
  assign span_neg  = (mx_q < dz_q);

  assign ddz       = {1'b0, t_cl[AVG_SHIFT+DEG_W-1:AVG_SHIFT]} - {1'b0, dz_q};
  assign ddz_neg   = -ddz;
  assign dmag      = ddz[DEG_W] ? ddz_neg : ddz;
  assign span      = {1'b0, mx_q} - {1'b0, dz_q};
  assign span_negv = -span;
  assign smag      = span[DEG_W] ? span_negv[DVS_W-1:0] : span[DVS_W-1:0];
  assign hl        = {1'b0, hi_q} - {1'b0, lo_q};

  assign num_neg = -mul_prod;
  assign nmag    = mul_prod[PROD_W-1] ? num_neg[DVD_W-1:0] : mul_prod[DVD_W-1:0];
  assign sum     = {1'b0, div_quo} + {{(DVD_W+1-CODE_W){1'b0}}, lo_q};

  always_comb begin
    if (idle_q) begin
      code_next = (lo_q > hi_q) ? hi_q : lo_q;
    end else if (neg_q && (div_quo != '0)) begin
      code_next = lo_q;
    end else if (sum > {{(DVD_W+1-CODE_W){1'b0}}, hi_q}) begin
      code_next = hi_q;
    end else begin
      code_next = sum[CODE_W-1:0];
    end
  end

  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_q)
      S_IDLE: begin
        mul_req.start  = in_valid_i;
        mul_req.mcand  = {{(MCAND_W-SAMPLE_W){accel_sample_i[SAMPLE_W-1]}}, accel_sample_i};
        mul_req.mplier = RAW_SCALE;
      end
      S_RAW: begin
        mul_req.start  = mul_done;
        mul_req.mcand  = diff;
        mul_req.mplier = alpha_eff;
      end
      S_SEL: begin
        mul_req.start  = !(t_zero || span_zero);
        mul_req.mcand  = {{(MCAND_W-CODE_W-1){hl[CODE_W]}}, hl};
        mul_req.mplier = dmag;
      end
      S_MAP: begin
        div_req.start    = mul_done;
        div_req.dividend = nmag;
        div_req.divisor  = smag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      avg_q       <= '0;
      idle_q      <= 1'b0;
      dneg_q      <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      code_q      <= '0;
      tilt_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_LAST)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RAW;
          end
        end
        S_RAW: begin
          if (mul_done) begin
            state_q <= S_AVG;
          end
        end
        S_AVG: begin
          if (mul_done) begin
            avg_q   <= avg_new;
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          idle_q  <= t_zero || span_zero;
          dneg_q  <= ddz[DEG_W];
          state_q <= (t_zero || span_zero) ? S_LAST : S_MAP;
        end
        S_MAP: begin
          if (mul_done) begin
            neg_q   <= mul_prod[PROD_W-1] ^ dneg_q ^ span_neg;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            code_q      <= code_next;
            tilt_q      <= avg_q[TILT_W-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      dz_q    <= DZ_RST;
      mx_q    <= MAX_RST;
      lo_q    <= IDLE_RST;
      hi_q    <= HI_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA:    alpha_q <= cfg_data_i[ALPHA_W-1:0];
        CFG_DEADZONE: dz_q    <= cfg_data_i[DEG_W-1:0];
        CFG_MAX_TILT: mx_q    <= cfg_data_i[DEG_W-1:0];
        CFG_IDLE:     lo_q    <= cfg_data_i[CODE_W-1:0];
        CFG_DAC_MAX:  hi_q    <= cfg_data_i[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign throttle_code_o = code_q;
  assign filtered_tilt_o = tilt_q;

endmodule

@@ rtl/ttc_checker.sv @@
module ttc_checker import ttc_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [CODE_W-1:0]          throttle_code_o,
  input logic signed [TILT_W-1:0]   filtered_tilt_o
);

  // an accepted sample keeps the block busy for the following cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // a new result only appears while the block is busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // a new result never appears on the cycle after an input transfer
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result without computation time");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(throttle_code_o) && $stable(filtered_tilt_o))
    else $error("stalled result changed");

endmodule

bind tilt_to_throttle_conditioner_unit ttc_checker u_ttc_checker (.*);

@@ sim/tilt_to_throttle_conditioner_unit_tb.sv @@
module tilt_to_throttle_conditioner_unit_tb;
  import ttc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS     = 5;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [CODE_W-1:0]        code;
    logic signed [TILT_W-1:0] tilt;
  } throttle_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] accel_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [CODE_W-1:0]          throttle_code_o;
  logic signed [TILT_W-1:0]   filtered_tilt_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;

  // shadow registers and filter state
  logic [ALPHA_W-1:0] alpha_cfg     = ALPHA_RST;
  logic [DEG_W-1:0]   deadzone_cfg  = DZ_RST;
  logic [DEG_W-1:0]   max_tilt_cfg  = MAX_RST;
  logic [CODE_W-1:0]  idle_code_cfg = IDLE_RST;
  logic [CODE_W-1:0]  max_code_cfg  = HI_RST;
  longint             tilt_avg_model = 0;

  throttle_result_t pending_throttle_q[$];
  int               mismatch_count = 0;
  int               stall_cycles = 0;
  bit               tx_gaps_on = 1'b1;
  bit               rx_gaps_on = 1'b1;
  int               rx_hold_cycles = 0;
  int               rx_stall_left = 0;
  int               target_q8 = 0;

  tilt_to_throttle_conditioner_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .accel_sample_i  (accel_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .throttle_code_o (throttle_code_o),
    .filtered_tilt_o (filtered_tilt_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Updates the filter state and returns the expected DAC code and tilt.
  function automatic throttle_result_t predict_throttle(logic signed [SAMPLE_W-1:0] sample);
    longint raw, alpha, t, d, code, dz, mx, lo, hi;
    throttle_result_t r;
    raw = (longint'(sample) * longint'(RAW_SCALE)) >>> RAW_SHIFT;
    alpha = (alpha_cfg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_cfg);
    tilt_avg_model = tilt_avg_model + ((alpha * (raw - tilt_avg_model)) >>> AVG_SHIFT);
    dz = longint'(deadzone_cfg);
    mx = longint'(max_tilt_cfg);
    lo = longint'(idle_code_cfg);
    hi = longint'(max_code_cfg);
    t = tilt_avg_model;
    if (t < (dz << AVG_SHIFT)) t = 0;
    if (t > (mx << AVG_SHIFT)) t = mx << AVG_SHIFT;
    if (t == 0 || mx == dz) begin
      code = lo;
    end else begin
      d = t >>> AVG_SHIFT;
      code = (d - dz) * (hi - lo) / (mx - dz) + lo;
    end
    if (code < lo) code = lo;
    else if (code > hi) code = hi;
    r.code = CODE_W'(code);
    r.tilt = TILT_W'(tilt_avg_model);
    return r;
  endfunction

  // Smallest sample whose scaled tilt reaches the given Q.8 angle.
  function automatic logic signed [SAMPLE_W-1:0] sample_for_tilt(int q8);
    longint s;
    longint scale;
    scale = longint'(RAW_SCALE);
    if (q8 >= 0) s = (longint'(q8) * (longint'(1) << RAW_SHIFT) + scale - 1) / scale;
    else s = (longint'(q8) * (longint'(1) << RAW_SHIFT)) / scale;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return SAMPLE_W'(s);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int unsigned p;
    int q8;
    p = $urandom_range(0, 99);
    if (p < 20) return SAMPLE_W'($urandom);
    if (p < 25) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    q8 = target_q8 + int'($urandom_range(0, 1024)) - 512;
    return sample_for_tilt(q8);
  endfunction

  task automatic send_sample(logic signed [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    accel_sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    pending_throttle_q.push_back(predict_throttle(sample));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_throttle_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ALPHA:    alpha_cfg     = data[ALPHA_W-1:0];
      CFG_DEADZONE: deadzone_cfg  = data[DEG_W-1:0];
      CFG_MAX_TILT: max_tilt_cfg  = data[DEG_W-1:0];
      CFG_IDLE:     idle_code_cfg = data[CODE_W-1:0];
      CFG_DAC_MAX:  max_code_cfg  = data[CODE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all_regs(int alpha, int dz, int mx, int lo, int hi);
    write_reg(CFG_ALPHA, CFG_DATA_W'(alpha));
    write_reg(CFG_DEADZONE, CFG_DATA_W'(dz));
    write_reg(CFG_MAX_TILT, CFG_DATA_W'(mx));
    write_reg(CFG_IDLE, CFG_DATA_W'(lo));
    write_reg(CFG_DAC_MAX, CFG_DATA_W'(hi));
  endtask

  // upper bits above each register width are random to exercise masking
  task automatic randomize_regs();
    int alpha, dz, mx, lo, hi;
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 9))
      0: alpha = 0;
      1: alpha = int'(ALPHA_ONE);
      2: alpha = $urandom_range(int'(ALPHA_ONE) + 1, (1 << ALPHA_W) - 1);
      default: alpha = $urandom_range(1, int'(ALPHA_ONE));
    endcase
    dz = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
    mx = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : dz + $urandom_range(0, 60);
    if (mx > 255) mx = 255;
    lo = $urandom_range(0, (1 << CODE_W) - 1);
    hi = ($urandom_range(0, 9) < 7) ? $urandom_range(lo, (1 << CODE_W) - 1)
                                     : $urandom_range(0, (1 << CODE_W) - 1);
    write_all_regs({junk[CFG_DATA_W-1:ALPHA_W], ALPHA_W'(alpha)},
                   {junk[CFG_DATA_W-1:DEG_W], DEG_W'(dz)},
                   {~junk[CFG_DATA_W-1:DEG_W], DEG_W'(mx)}, lo, hi);
  endtask

  task automatic test_reset_regs();
    send_sample(16'sh0000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
    wait_idle();
  endtask

  task automatic test_tilt_windows();
    write_reg(CFG_ALPHA, CFG_DATA_W'(ALPHA_ONE));
    send_sample(SAMPLE_W'(sample_for_tilt(6 * 256) - 1));
    send_sample(sample_for_tilt(6 * 256));
    send_sample(sample_for_tilt(13 * 256));
    send_sample(sample_for_tilt(20 * 256));
    send_sample(SAMPLE_W'(sample_for_tilt(20 * 256) + 1));
    send_sample(16'sh7FFF);
    send_sample(-16'sd5000);
    wait_idle();
  endtask

  task automatic test_alpha_limits();
    write_reg(CFG_ALPHA, '0);
    send_sample(16'sh7FFF);
    wait_idle();
    write_reg(CFG_ALPHA, '1);
    send_sample(sample_for_tilt(15 * 256));
    send_sample(16'sh8000);
    wait_idle();
  endtask

  task automatic test_span_cases();
    // zero span
    write_all_regs(int'(ALPHA_ONE), 10, 10, 750, 1150);
    send_sample(sample_for_tilt(15 * 256));
    send_sample(sample_for_tilt(5 * 256));
    wait_idle();
    // max tilt below deadzone
    write_all_regs(int'(ALPHA_ONE), 30, 10, 750, 1150);
    send_sample(sample_for_tilt(40 * 256));
    send_sample(sample_for_tilt(20 * 256));
    wait_idle();
    // idle code above full-throttle code
    write_all_regs(int'(ALPHA_ONE), 6, 20, 3000, 100);
    send_sample(sample_for_tilt(13 * 256));
    wait_idle();
    write_all_regs(int'(ALPHA_ONE), 0, 0, 0, 0);
    send_sample(sample_for_tilt(40 * 256));
    wait_idle();
    write_all_regs(int'(ALPHA_ONE), '1, '1, '1, '1);
    send_sample(16'sh7FFF);
    wait_idle();
    write_all_regs(int'(ALPHA_ONE), 0, 255, 0, 4095);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    wait_idle();
  endtask

  task automatic test_unused_index();
    write_all_regs(int'(ALPHA_ONE), 6, 20, 750, 1150);
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) write_reg(CFG_IDX_W'(i), '1);
    send_sample(sample_for_tilt(10 * 256));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 10; phase++) begin
      randomize_regs();
      tx_gaps_on = (phase != 3) && (phase != 7);
      rx_gaps_on = (phase != 3) && (phase != 5);
      for (int n = 0; n < 50; n++) begin
        if (n % 8 == 0) begin
          target_q8 = int'($urandom_range(0, 100 * 256));
          if ($urandom_range(0, 7) == 0) target_q8 = -target_q8;
        end
        send_sample(random_sample());
      end
      wait_idle();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    write_all_regs(128, 4, 40, 100, 4000);
    tx_gaps_on = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    for (int n = 0; n < 16; n++) begin
      target_q8 = int'($urandom_range(0, 50 * 256));
      send_sample(random_sample());
    end
    tx_gaps_on = 1'b1;
    wait_idle();
  endtask

  // receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left != 0) begin
        out_ready_i <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        rx_stall_left = rx_gaps_on ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    throttle_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_throttle_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result code %0d tilt %0d", $realtime,
                   throttle_code_o, filtered_tilt_o);
      end else begin
        exp_r = pending_throttle_q.pop_front();
        if (throttle_code_o !== exp_r.code || filtered_tilt_o !== exp_r.tilt) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected code %0d tilt %0d, got code %0d tilt %0d", $realtime,
                     exp_r.code, exp_r.tilt, throttle_code_o, filtered_tilt_o);
        end
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_regs();
    test_tilt_windows();
    test_alpha_limits();
    test_span_cases();
    test_unused_index();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ttc_pkg.sv
rtl/ttc_mul.sv
rtl/ttc_div.sv
rtl/tilt_to_throttle_conditioner_unit.sv
rtl/ttc_checker.sv
sim/tilt_to_throttle_conditioner_unit_tb.sv
